// ----- design/utt_pkg.sv -----
// Package for the UTF-8 to UTF-16 transcoder: item types, decoder state,
// result group and the byte-level decode functions. No dependencies.
package utt_pkg;

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE        = 21'h10000;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
  localparam int          MAX_UNITS        = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } out_item_t;

  // Bytes held after a lead byte, how many are held, and the total length
  // of the sequence being collected (zero when none is).
  typedef struct packed {
    logic [2:0][7:0] pending_bytes;
    logic [1:0]      pending_count;
    logic [2:0]      needed_length;
  } dec_state_t;

  // Units produced for one input item.
  typedef struct packed {
    out_item_t [MAX_UNITS-1:0] units;
    logic [2:0]                count;
  } dec_result_t;

  // One code point as UTF-16: one unit, or a surrogate pair.
  typedef struct packed {
    logic        is_pair;
    logic [15:0] first;
    logic [15:0] second;
  } utf16_pair_t;

  // Sequence length for a lead byte; zero means the byte cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                      len = 3'd1;
    else if (b[7:5] == 3'b110)      len = 3'd2;
    else if (b[7:4] == 4'b1110)     len = 3'd3;
    else if (b[7:3] == 5'b11110)    len = 3'd4;
    else                            len = 3'd0;
    return len;
  endfunction

  // Code point from k bytes; continuation bytes keep their low six bits.
  function automatic logic [20:0] decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] k);
    logic [20:0] cp;
    case (k)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  // Values at or above the supplementary base are split into a pair.
  function automatic utf16_pair_t to_utf16(input logic [20:0] cp);
    utf16_pair_t r;
    logic [20:0] v;
    v = cp - SUPP_BASE;
    r.is_pair = (cp >= SUPP_BASE);
    if (r.is_pair) begin
      r.first  = HIGH_SURR_BASE + {5'd0, v[20:10]};
      r.second = LOW_SURR_BASE + {6'd0, v[9:0]};
    end else begin
      r.first  = cp[15:0];
      r.second = '0;
    end
    return r;
  endfunction

endpackage

// ----- design/utt_decoder.sv -----
// Combinational decoder: one byte plus the held sequence state in, the
// UTF-16 units for that byte and the next state out. Uses utt_pkg.
module utt_decoder import utt_pkg::*; (
  input  dec_state_t  state,
  input  in_item_t    item,
  output dec_state_t  state_next,
  output dec_result_t result
);

  always_comb begin
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic [2:0]      pos;
    logic [2:0]      k;
    logic [2:0]      n;
    logic [20:0]     cp;
    logic            emit;
    utf16_pair_t     pair;

    // Held bytes followed by the new byte.
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < {1'b0, state.pending_count}) begin
        bytes[i] = state.pending_bytes[i];
      end else if (3'(i) == {1'b0, state.pending_count}) begin
        bytes[i] = item.in_byte;
      end else begin
        bytes[i] = '0;
      end
    end
    len = {1'b0, state.pending_count} + 3'd1;

    state_next   = state;
    result       = '0;
    n            = '0;
    pos          = '0;
    cp           = '0;
    emit         = 1'b0;
    k            = '0;
    pair         = '0;

    if (item.final_byte) begin
      // End of string: rescan everything held, a lead byte whose sequence
      // runs past the end becomes the replacement character.
      for (int s = 0; s < 4; s++) begin
        if (pos < len) begin
          k = lead_len(bytes[pos[1:0]]);
          if (k != 3'd0 && ({1'b0, pos} + {1'b0, k}) <= {1'b0, len}) begin
            cp  = decode_seq(bytes[pos[1:0]], bytes[2'(pos + 3'd1)],
                             bytes[2'(pos + 3'd2)], bytes[2'(pos + 3'd3)], k);
            pos = pos + k;
          end else begin
            cp  = {5'd0, REPLACEMENT_CHAR};
            pos = pos + 3'd1;
          end
          pair = to_utf16(cp);
          result.units[n[1:0]].code_unit = pair.first;
          if (pair.is_pair) begin
            result.units[2'(n + 3'd1)].code_unit = pair.second;
            n = n + 3'd2;
          end else begin
            n = n + 3'd1;
          end
        end
      end
      result.units[2'(n - 3'd1)].last_unit = 1'b1;
      state_next.pending_count = '0;
      state_next.needed_length = '0;
    end else if (state.needed_length == 3'd0) begin
      k = lead_len(item.in_byte);
      if (k == 3'd0) begin
        cp   = {5'd0, REPLACEMENT_CHAR};
        emit = 1'b1;
      end else if (k == 3'd1) begin
        cp   = {13'd0, item.in_byte};
        emit = 1'b1;
      end else begin
        state_next.pending_bytes[0] = item.in_byte;
        state_next.pending_count    = 2'd1;
        state_next.needed_length    = k;
      end
    end else if (len >= state.needed_length) begin
      cp   = decode_seq(bytes[0], bytes[1], bytes[2], bytes[3], len);
      emit = 1'b1;
      state_next.pending_count = '0;
      state_next.needed_length = '0;
    end else begin
      state_next.pending_bytes[state.pending_count] = item.in_byte;
      state_next.pending_count = state.pending_count + 2'd1;
    end

    if (emit) begin
      pair = to_utf16(cp);
      result.units[0].code_unit = pair.first;
      result.units[1].code_unit = pair.second;
      n = pair.is_pair ? 3'd2 : 3'd1;
    end
    result.count = n;
  end

endmodule

// ----- design/utf8_to_utf16_transcoder_top.sv -----
// Top level of the UTF-8 to UTF-16 transcoder: sequence state registers,
// result buffer and output drain. Uses utt_pkg and utt_decoder.
//
// Usage: bytes of a UTF-8 string arrive on the in channel (in_valid,
// in_ready, in_item), one byte per item, with final_byte set on the last
// byte. UTF-16 code units leave on the out channel (out_valid, out_ready,
// out_item), one unit per item, with last_unit set on the final unit of
// the string.
// Latency: the first unit for a byte is offered in the cycle after that
// byte is accepted. Bytes that only extend a sequence produce no unit.
// Throughput: one byte per cycle while each byte yields at most one unit
// and out_ready is high. A byte yielding more (a surrogate pair, or an
// early end of string that flushes up to four units) holds the input until
// they leave, as the four-entry result buffer drains one unit per cycle
// into the out port. The next byte is taken in the same cycle as the last unit.
// Reset: rst, synchronous and active high, empties the result buffer and
// drops any partially collected sequence; held bytes are not cleared.
// Stall: when out_ready is low, buffered units wait and no byte is
// accepted while any unit is still waiting in the buffer.
module utf8_to_utf16_transcoder_top import utt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t dec_result;

  // Result buffer: units of the last accepted byte, a read pointer and the
  // number of units still to deliver.
  out_item_t [MAX_UNITS-1:0] res_units;
  logic [1:0]                res_idx;
  logic [2:0]                res_count;

  logic in_fire;
  logic out_fire;

  utt_decoder u_decoder (
    .state      (state),
    .item       (in_item),
    .state_next (state_next),
    .result     (dec_result)
  );

  // The buffer can take a new byte's units once it is empty or its last
  // unit is leaving in this cycle.
  assign in_ready  = (res_count == 3'd0) || (res_count == 3'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (res_count != 3'd0);
  assign out_fire  = out_valid && out_ready;
  assign out_item  = res_units[res_idx];

  // Sequence state: held bytes carry no reset, the counts do.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      state.pending_bytes <= state_next.pending_bytes;
    end
    if (rst) begin
      state.pending_count <= '0;
      state.needed_length <= '0;
    end else if (in_fire) begin
      state.pending_count <= state_next.pending_count;
      state.needed_length <= state_next.needed_length;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_units <= dec_result.units;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
      res_idx   <= '0;
    end else if (in_fire) begin
      res_count <= dec_result.count;
      res_idx   <= '0;
    end else if (out_fire) begin
      res_count <= res_count - 3'd1;
      res_idx   <= res_idx + 2'd1;
    end
  end

endmodule
